/* hw/rtl/chtx_pkg.sv */
// Package: shared widths, opcodes and status codes of the chained hash table.
`default_nettype none
package chtx_pkg;
  localparam int KEY_W   = 31;
  localparam int VAL_W   = 64;
  localparam int LIFE_W  = 32;
  localparam int CFG_W   = 6;
  localparam int BCNT_RESET = 20;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_LOOKUP = 2'd2,
    OP_TICK   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_MISS    = 2'd1,
    ST_EXPIRED = 2'd2,
    ST_FULL    = 2'd3
  } status_t;
endpackage
`default_nettype wire

/* hw/rtl/chtx_if.sv */
// Interfaces: request and result channels of the chained hash table.
`default_nettype none
interface chtx_in_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    operation;
  logic [chtx_pkg::KEY_W-1:0]    key;
  logic [chtx_pkg::VAL_W-1:0]    value_word;
  logic [chtx_pkg::LIFE_W-1:0]   lifespan;
  modport source (output valid, operation, key, value_word, lifespan, input ready);
  modport sink   (input valid, operation, key, value_word, lifespan, output ready);
endinterface

interface chtx_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    status;
  logic [chtx_pkg::VAL_W-1:0]    found_value;
  modport source (output valid, status, found_value, input ready);
  modport sink   (input valid, status, found_value, output ready);
endinterface
`default_nettype wire

/* hw/rtl/chtx_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module chtx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic                                     clk,
  input  wire logic                                     we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                         wdata,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

/* hw/rtl/chtx_mod.sv */
// Bit-serial restoring remainder unit: key modulo bucket count.
`default_nettype none
module chtx_mod (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         start,
  input  wire logic [chtx_pkg::KEY_W-1:0]   dividend,
  input  wire logic [chtx_pkg::CFG_W-1:0]   divisor,
  output logic                              done,
  output logic      [chtx_pkg::CFG_W-1:0]   rem
);
  import chtx_pkg::*;

  logic [KEY_W-1:0]  dvd_r;
  logic [CFG_W-1:0]  dvs_r;
  logic [CFG_W-1:0]  rem_r;
  logic [4:0]        cnt_r;
  logic              busy_r;
  logic              done_r;
  logic [CFG_W:0]    shifted;
  logic [CFG_W-1:0]  rem_nxt;

  always_comb begin
    shifted = {rem_r, dvd_r[cnt_r]};
    if (shifted >= {1'b0, dvs_r}) begin
      rem_nxt = CFG_W'(shifted - {1'b0, dvs_r});
    end else begin
      rem_nxt = shifted[CFG_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      rem_r  <= '0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        rem_r  <= '0;
        cnt_r  <= 5'(KEY_W - 1);
        busy_r <= 1'b1;
      end else if (busy_r) begin
        rem_r <= rem_nxt;
        cnt_r <= cnt_r - 5'd1;
        if (cnt_r == 5'd0) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      dvd_r <= dividend;
      dvs_r <= divisor;
    end
  end

  assign done = done_r;
  assign rem  = rem_r;
endmodule
`default_nettype wire

/* hw/rtl/chained_hash_table_with_expiry_top.sv */
// Top level: chained hash table with per-entry expiry, sequencer and memories.
//
// channel  dir  handshake          payload
// in_req   in   valid/ready        operation, key, value_word, lifespan
// out_res  out  valid/ready        status, found_value
// cfg      in   APB psel/penable   bucket_count at byte address 0
//
// Tick and a full-pool insert skip the bit-serial modulo; other inserts run it first.
// Delete and lookup run the modulo, then fetch and compare each chain entry visited.
// After reset a clearing pass over max(POOL_ENTRIES, MAX_BUCKETS) addresses fills the
// bucket heads and free list; no request is taken meanwhile.
// A result waits in the output register; the next request is taken while it waits.
`default_nettype none
module chained_hash_table_with_expiry_top #(
  parameter int POOL_ENTRIES = 64,
  parameter int MAX_BUCKETS  = 32
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  chtx_in_if.sink                          in_req,
  chtx_out_if.source                       out_res,
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [2:0]                  paddr,
  input  wire logic [31:0]                 pwdata,
  output logic      [31:0]                 prdata,
  output logic                             pready
);
  import chtx_pkg::*;

  localparam int AW   = $clog2(POOL_ENTRIES);
  localparam int PW   = AW + 1;
  localparam int BW   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
  localparam int CLRN = (POOL_ENTRIES > MAX_BUCKETS) ? POOL_ENTRIES : MAX_BUCKETS;
  localparam int CW   = $clog2(CLRN) + 1;
  localparam int EW   = KEY_W + VAL_W + 2 * LIFE_W;
  localparam logic [PW-1:0] NIL = PW'(POOL_ENTRIES);

  typedef enum logic [7:0] {
    S_CLEAR = 8'b00000001,
    S_IDLE  = 8'b00000010,
    S_DIV   = 8'b00000100,
    S_INS   = 8'b00001000,
    S_HEAD  = 8'b00010000,
    S_FETCH = 8'b00100000,
    S_CMP   = 8'b01000000,
    S_DONE  = 8'b10000000
  } state_t;

  state_t             state_r;
  logic [CFG_W-1:0]   bcnt_r;
  logic [1:0]         op_r;
  logic [KEY_W-1:0]   key_r;
  logic [VAL_W-1:0]   val_r;
  logic [LIFE_W-1:0]  life_r;
  logic [LIFE_W-1:0]  now_r;
  logic [PW-1:0]      free_cnt_r;
  logic [PW-1:0]      cur_r;
  logic [PW-1:0]      prev_r;
  logic [PW-1:0]      steps_r;
  logic [CW-1:0]      clr_r;
  logic [1:0]         res_status_r;
  logic [VAL_W-1:0]   res_value_r;
  logic               out_valid_r;
  logic [1:0]         out_status_r;
  logic [VAL_W-1:0]   out_value_r;

  logic               accept;
  logic               div_start;
  logic               div_done;
  logic [CFG_W-1:0]   div_rem;
  logic [CFG_W-1:0]   n_eff;
  logic [31:0]        n32;
  logic [31:0]        rem32;
  logic [BW-1:0]      bucket;
  logic [31:0]        clr32;

  logic               ent_we;
  logic [EW-1:0]      ent_rdata;
  logic               nxt_we;
  logic [AW-1:0]      nxt_waddr;
  logic [PW-1:0]      nxt_wdata;
  logic [PW-1:0]      nxt_rdata;
  logic               head_we;
  logic [BW-1:0]      head_waddr;
  logic [PW-1:0]      head_wdata;
  logic [PW-1:0]      head_rdata;
  logic               free_we;
  logic [AW-1:0]      free_waddr;
  logic [PW-1:0]      free_wdata;
  logic [PW-1:0]      free_rdata;

  logic [KEY_W-1:0]   e_key;
  logic [VAL_W-1:0]   e_val;
  logic [LIFE_W-1:0]  e_life;
  logic [LIFE_W-1:0]  e_birth;
  logic               match;
  logic               expired;
  logic               unlink;
  logic               clearing;

  assign pready = 1'b1;
  assign prdata = 32'(bcnt_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bcnt_r <= CFG_W'(BCNT_RESET);
    end else if (psel && penable && pwrite && !paddr[2]) begin
      bcnt_r <= pwdata[CFG_W-1:0];
    end
  end

  always_comb begin
    if (bcnt_r == '0) begin
      n32 = 32'd1;
    end else if (32'(bcnt_r) > 32'(MAX_BUCKETS)) begin
      n32 = 32'(MAX_BUCKETS);
    end else begin
      n32 = 32'(bcnt_r);
    end
    n_eff  = n32[CFG_W-1:0];
    rem32  = 32'(div_rem);
    bucket = rem32[BW-1:0];
    clr32  = 32'(clr_r);
  end

  assign accept    = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == S_IDLE);
  assign div_start = accept && (in_req.operation != OP_TICK) &&
                     !((in_req.operation == OP_INSERT) && (free_cnt_r == '0));

  chtx_mod u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (in_req.key),
    .divisor  (n_eff),
    .done     (div_done),
    .rem      (div_rem)
  );

  assign {e_key, e_val, e_life, e_birth} = ent_rdata;
  assign match    = (e_key == key_r);
  assign expired  = (LIFE_W'(now_r - e_birth) >= e_life);
  assign unlink   = (state_r == S_CMP) && match &&
                    ((op_r == OP_DELETE) || expired);
  assign clearing = (state_r == S_CLEAR);

  always_comb begin
    ent_we     = (state_r == S_INS);
    nxt_we     = 1'b0;
    nxt_waddr  = free_rdata[AW-1:0];
    nxt_wdata  = head_rdata;
    head_we    = 1'b0;
    head_waddr = bucket;
    head_wdata = free_rdata;
    free_we    = 1'b0;
    free_waddr = free_cnt_r[AW-1:0];
    free_wdata = cur_r;
    if (clearing) begin
      head_we    = (clr32 < 32'(MAX_BUCKETS));
      head_waddr = clr32[BW-1:0];
      head_wdata = NIL;
      free_we    = (clr32 < 32'(POOL_ENTRIES));
      free_waddr = clr32[AW-1:0];
      free_wdata = PW'(32'(POOL_ENTRIES - 1) - clr32);
    end else if (state_r == S_INS) begin
      nxt_we  = 1'b1;
      head_we = 1'b1;
    end else if (unlink) begin
      free_we = 1'b1;
      if (prev_r != NIL) begin
        nxt_we    = 1'b1;
        nxt_waddr = prev_r[AW-1:0];
        nxt_wdata = nxt_rdata;
      end else begin
        head_we    = 1'b1;
        head_wdata = nxt_rdata;
      end
    end
  end

  chtx_ram #(.WIDTH(EW), .DEPTH(POOL_ENTRIES)) u_ent (
    .clk (clk), .we (ent_we), .waddr (free_rdata[AW-1:0]),
    .wdata ({key_r, val_r, life_r, now_r}), .raddr (cur_r[AW-1:0]), .rdata (ent_rdata)
  );

  chtx_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_nxt (
    .clk (clk), .we (nxt_we), .waddr (nxt_waddr),
    .wdata (nxt_wdata), .raddr (cur_r[AW-1:0]), .rdata (nxt_rdata)
  );

  chtx_ram #(.WIDTH(PW), .DEPTH(MAX_BUCKETS)) u_head (
    .clk (clk), .we (head_we), .waddr (head_waddr),
    .wdata (head_wdata), .raddr (bucket), .rdata (head_rdata)
  );

  chtx_ram #(.WIDTH(PW), .DEPTH(POOL_ENTRIES)) u_free (
    .clk (clk), .we (free_we), .waddr (free_waddr),
    .wdata (free_wdata), .raddr (AW'(free_cnt_r - PW'(1))), .rdata (free_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_CLEAR;
      clr_r      <= '0;
      free_cnt_r <= PW'(POOL_ENTRIES);
      now_r      <= '0;
    end else begin
      unique case (state_r)
        S_CLEAR: begin
          clr_r <= clr_r + CW'(1);
          if (clr32 == 32'(CLRN - 1)) begin
            state_r <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (accept) begin
            res_value_r <= '0;
            if (in_req.operation == OP_TICK) begin
              now_r        <= now_r + LIFE_W'(1);
              res_status_r <= ST_OK;
              state_r      <= S_DONE;
            end else if (!div_start) begin
              res_status_r <= ST_FULL;
              state_r      <= S_DONE;
            end else begin
              state_r <= S_DIV;
            end
          end
        end
        S_DIV: begin
          if (div_done) begin
            state_r <= (op_r == OP_INSERT) ? S_INS : S_HEAD;
          end
        end
        S_INS: begin
          free_cnt_r   <= free_cnt_r - PW'(1);
          res_status_r <= ST_OK;
          state_r      <= S_DONE;
        end
        S_HEAD: begin
          cur_r   <= head_rdata;
          prev_r  <= NIL;
          steps_r <= '0;
          if (head_rdata == NIL) begin
            res_status_r <= ST_MISS;
            state_r      <= S_DONE;
          end else begin
            state_r <= S_FETCH;
          end
        end
        S_FETCH: begin
          state_r <= S_CMP;
        end
        S_CMP: begin
          if (match) begin
            state_r <= S_DONE;
            if (unlink) begin
              free_cnt_r <= free_cnt_r + PW'(1);
            end
            if (op_r == OP_DELETE) begin
              res_status_r <= ST_OK;
            end else if (expired) begin
              res_status_r <= ST_EXPIRED;
            end else begin
              res_status_r <= ST_OK;
              res_value_r  <= e_val;
            end
          end else if ((nxt_rdata == NIL) || (steps_r + PW'(1) == NIL)) begin
            res_status_r <= ST_MISS;
            state_r      <= S_DONE;
          end else begin
            prev_r  <= cur_r;
            cur_r   <= nxt_rdata;
            steps_r <= steps_r + PW'(1);
            state_r <= S_FETCH;
          end
        end
        S_DONE: begin
          if (!out_valid_r || out_res.ready) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_CLEAR;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op_r   <= in_req.operation;
      key_r  <= in_req.key;
      val_r  <= in_req.value_word;
      life_r <= in_req.lifespan;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if ((state_r == S_DONE) && (!out_valid_r || out_res.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_res.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if ((state_r == S_DONE) && (!out_valid_r || out_res.ready)) begin
      out_status_r <= res_status_r;
      out_value_r  <= res_value_r;
    end
  end

  assign out_res.valid       = out_valid_r;
  assign out_res.status      = out_status_r;
  assign out_res.found_value = out_value_r;

  a_free_bound: assert property (@(posedge clk) disable iff (!rst_n)
    free_cnt_r <= PW'(POOL_ENTRIES))
    else $error("free count above pool size");

  a_walk_valid: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CMP) |-> (cur_r != NIL))
    else $error("chain walk on null entry");

  a_insert_pop: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_INS) |=> (free_cnt_r == $past(free_cnt_r) - PW'(1)))
    else $error("insert did not pop free list");

  a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r != S_IDLE))
    else $error("request accepted without leaving idle");
endmodule
`default_nettype wire

/* tb/tb_chained_hash_table_with_expiry_top.sv */
// Testbench: checks the chained hash table with expiry against its own predictor of table state.
module tb_chained_hash_table_with_expiry_top;
  import chtx_pkg::*;

  localparam int POOL = 64;
  localparam int NBKT = 32;
  localparam int NIL  = POOL;
  localparam logic [2:0] ADDR_BUCKET_COUNT = 3'd0;

  typedef struct packed {
    status_t     status;
    logic [63:0] found_value;
  } result_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  chtx_in_if  req_if ();
  chtx_out_if res_if ();

  chained_hash_table_with_expiry_top dut (
    .clk(clk), .rst_n(rst_n), .in_req(req_if.sink), .out_res(res_if.source),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  logic [30:0] tbl_key [POOL];
  logic [63:0] tbl_value [POOL];
  logic [31:0] tbl_life [POOL];
  logic [31:0] tbl_birth [POOL];
  int          tbl_next [POOL];
  int          chain_head [NBKT];
  int          free_pool [POOL];
  int          free_count;
  logic [31:0] seconds;
  logic [5:0]  bucket_count;

  result_t expected_results[$];
  int errors = 0;
  bit stall_mode = 1'b0;
  logic [30:0] hot_keys[8];

  initial begin
    req_if.valid = 1'b0;
    req_if.operation = OP_TICK;
    req_if.key = '0;
    req_if.value_word = '0;
    req_if.lifespan = '0;
    res_if.ready = 1'b0;
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    $display("mismatch %s: got %0h expected %0h at %0t", what, got, want, $time);
    errors++;
  endtask

  function automatic int table_bucket(input logic [30:0] k);
    int n;
    n = int'(bucket_count);
    if (n == 0) n = 1;
    if (n > NBKT) n = NBKT;
    return k % n;
  endfunction

  function automatic void table_reset();
    for (int i = 0; i < POOL; i++) begin
      tbl_next[i] = NIL;
      free_pool[i] = POOL - 1 - i;
    end
    for (int i = 0; i < NBKT; i++) chain_head[i] = NIL;
    free_count = POOL;
    seconds = '0;
    bucket_count = 6'(BCNT_RESET);
  endfunction

  function automatic void table_unlink(input int b, input int idx, input int prev);
    if (prev < NIL) tbl_next[prev] = tbl_next[idx];
    else chain_head[b] = tbl_next[idx];
    if (free_count < POOL) free_pool[free_count++] = idx;
  endfunction

  function automatic result_t table_apply(input op_t op, input logic [30:0] k,
                                          input logic [63:0] v, input logic [31:0] life);
    result_t r;
    int b, idx, prev, cur, steps;
    r.status = ST_OK;
    r.found_value = '0;
    b = table_bucket(k);
    idx = NIL;
    prev = NIL;
    if (op == OP_DELETE || op == OP_LOOKUP) begin
      cur = chain_head[b];
      steps = 0;
      while (steps < POOL && cur < NIL) begin
        if (tbl_key[cur] == k) begin
          idx = cur;
          break;
        end
        prev = cur;
        cur = tbl_next[cur];
        steps++;
      end
      if (idx == NIL) prev = NIL;
    end
    case (op)
      OP_INSERT: begin
        if (free_count == 0) r.status = ST_FULL;
        else begin
          idx = free_pool[--free_count];
          tbl_key[idx] = k;
          tbl_value[idx] = v;
          tbl_life[idx] = life;
          tbl_birth[idx] = seconds;
          tbl_next[idx] = chain_head[b];
          chain_head[b] = idx;
        end
      end
      OP_DELETE: begin
        if (idx < NIL) table_unlink(b, idx, prev);
        else r.status = ST_MISS;
      end
      OP_LOOKUP: begin
        if (idx >= NIL) r.status = ST_MISS;
        else if (32'(seconds - tbl_birth[idx]) >= tbl_life[idx]) begin
          table_unlink(b, idx, prev);
          r.status = ST_EXPIRED;
        end else r.found_value = tbl_value[idx];
      end
      default: seconds = seconds + 32'd1;
    endcase
    return r;
  endfunction

  task automatic send_request(input op_t op, input logic [30:0] k,
                              input logic [63:0] v, input logic [31:0] life);
    req_if.valid <= 1'b1;
    req_if.operation <= op;
    req_if.key <= k;
    req_if.value_word <= v;
    req_if.lifespan <= life;
    do @(posedge clk); while (!req_if.ready);
    expected_results.push_back(table_apply(op, k, v, life));
    if ($urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  task automatic drain();
    int guard;
    req_if.valid <= 1'b0;
    guard = 0;
    while (expected_results.size() != 0 && guard < 200000) begin
      @(posedge clk);
      guard++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch("missing results", 64'(expected_results.size()), 64'd0);
      expected_results.delete();
    end
    repeat (200) @(posedge clk);
  endtask

  task automatic write_bucket_count(input logic [31:0] n);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= ADDR_BUCKET_COUNT;
    pwdata <= n;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    bucket_count = n[5:0];
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (res_if.valid && res_if.ready) begin
        if (expected_results.size() == 0) begin
          report_mismatch("unexpected result", {62'd0, res_if.status}, 64'd0);
        end else begin
          result_t e;
          e = expected_results.pop_front();
          if (res_if.status != e.status)
            report_mismatch("status", {62'd0, res_if.status}, {62'd0, e.status});
          if (res_if.found_value != e.found_value)
            report_mismatch("found_value", res_if.found_value, e.found_value);
        end
      end
      if ($urandom_range(0, 63) == 0) stall_mode <= ~stall_mode;
      res_if.ready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
    end
  end

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  task automatic test_directed();
    send_request(OP_LOOKUP, 31'h7FFF_FFFF, '0, '0);
    send_request(OP_INSERT, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_INSERT, 31'd0, 64'd0, 32'd0);
    send_request(OP_INSERT, 31'd20, 64'h5555_AAAA_5555_AAAA, 32'd2);
    send_request(OP_INSERT, 31'd20, 64'hAAAA_5555_AAAA_5555, 32'd1);
    send_request(OP_LOOKUP, 31'h7FFF_FFFF, '0, '0);
    send_request(OP_LOOKUP, 31'd0, '0, '0);
    send_request(OP_LOOKUP, 31'd0, '0, '0);
    send_request(OP_LOOKUP, 31'd20, '0, '0);
    send_request(OP_TICK, '0, '0, '0);
    send_request(OP_LOOKUP, 31'd20, '0, '0);
    send_request(OP_LOOKUP, 31'd20, '0, '0);
    send_request(OP_TICK, 31'h7FFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 32'hFFFF_FFFF);
    send_request(OP_LOOKUP, 31'd20, '0, '0);
    send_request(OP_DELETE, 31'd40, '0, '0);
    send_request(OP_DELETE, 31'h7FFF_FFFF, '0, '0);
    send_request(OP_DELETE, 31'h7FFF_FFFF, '0, '0);
    drain();
  endtask

  task automatic test_pool_full();
    for (int i = 0; i < POOL + 3; i++)
      send_request(OP_INSERT, 31'($urandom_range(0, 200)), rand64(), 32'hFFFF_FFFF);
    for (int i = 0; i < POOL + 3; i++)
      send_request(OP_DELETE, 31'($urandom_range(0, 200)), '0, '0);
    drain();
  endtask

  task automatic test_random(input int count, input int key_span);
    op_t op;
    logic [30:0] k;
    logic [31:0] life;
    for (int i = 0; i < 8; i++) hot_keys[i] = 31'($urandom());
    for (int i = 0; i < count; i++) begin
      op = op_t'($urandom_range(0, 9) < 3 ? OP_INSERT :
                 $urandom_range(0, 2) == 0 ? OP_DELETE :
                 $urandom_range(0, 3) == 0 ? OP_TICK : OP_LOOKUP);
      case ($urandom_range(0, 3))
        0: k = 31'($urandom());
        1: k = hot_keys[$urandom_range(0, 7)];
        default: k = 31'($urandom_range(0, key_span));
      endcase
      life = ($urandom_range(0, 4) == 0) ? $urandom() : 32'($urandom_range(0, 4));
      send_request(op, k, rand64(), life);
    end
    drain();
  endtask

  initial begin
    table_reset();
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    repeat (80) @(posedge clk);
    test_directed();
    test_pool_full();
    test_random(400, 100);
    write_bucket_count(32'd1);
    test_random(200, 40);
    write_bucket_count(32'd32);
    test_random(250, 200);
    write_bucket_count(32'd0);
    test_random(100, 30);
    write_bucket_count(32'd63);
    test_random(150, 100);
    write_bucket_count(32'd7);
    test_random(150, 60);
    if (errors == 0) begin
      $display("tb_chained_hash_table_with_expiry_top: PASS");
    end else begin
      $display("tb_chained_hash_table_with_expiry_top: FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("tb_chained_hash_table_with_expiry_top: FAIL");
    $finish;
  end
endmodule
